>>> hw/rtl/thmc_pkg.sv
package thmc_pkg;

    localparam int HANDLE_W = 16;
    localparam int ADDR_W   = 32;
    localparam int SRC_W    = 3;

    // result source codes
    localparam logic [SRC_W-1:0] SRC_HOT    = 3'd0;
    localparam logic [SRC_W-1:0] SRC_TABLE  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_NEW    = 3'd2;
    localparam logic [SRC_W-1:0] SRC_FAIL   = 3'd3;
    localparam logic [SRC_W-1:0] SRC_BYPASS = 3'd4;

    // classified request as it travels from front to back
    typedef struct packed {
        logic                bypass;
        logic [HANDLE_W-1:0] handle;
        logic                mapper_ok;
        logic [ADDR_W-1:0]   mapper_addr;
    } t_req;

    // one stored mapping
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ADDR_W-1:0]   addr;
    } t_entry;

endpackage

>>> hw/rtl/thmc_front.sv
module thmc_front
    import thmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cache_enable,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_mapper_ok,
    input  logic [ADDR_W-1:0]   i_mapper_addr,
    output logic                o_head_valid,
    output t_req                o_head,
    input  logic                i_pop
);

    t_req       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_req       req;

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_slot[r_rd_ptr];

    // classify: bypass is fixed by the enable at accept time
    always_comb begin
        req.bypass      = !i_cache_enable;
        req.handle      = i_handle;
        req.mapper_ok   = i_mapper_ok;
        req.mapper_addr = i_mapper_addr;
    end

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= req;
        end
    end

endmodule

>>> hw/rtl/thmc_back.sv
module thmc_back
    import thmc_pkg::*;
#(
    parameter int HOT_ENTRIES   = 16,
    parameter int TABLE_ENTRIES = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_req              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_mapped_addr,
    output logic [SRC_W-1:0]  o_source
);

    localparam int HW = (HOT_ENTRIES > 1) ? $clog2(HOT_ENTRIES) : 1;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [FW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [FW-1:0]       r_fill;
    logic [HW-1:0]       r_victim;
    logic                r_hot_valid   [HOT_ENTRIES];
    logic [HANDLE_W-1:0] r_hot_handle  [HOT_ENTRIES];
    logic [ADDR_W-1:0]   r_hot_address [HOT_ENTRIES];
    t_entry              r_mem [TABLE_ENTRIES];
    t_entry              r_rd_data;
    logic                r_out_valid;
    logic                r_out_found;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [SRC_W-1:0]    r_out_src;

    logic                hot_hit;
    logic [HW-1:0]       hot_idx;
    logic                finish;
    logic                go;
    logic                out_free;
    logic                rd_en;
    logic                hot_wr;
    logic [ADDR_W-1:0]   hot_wr_addr;
    logic                tbl_wr;
    logic                res_found;
    logic [ADDR_W-1:0]   res_addr;
    logic [SRC_W-1:0]    res_src;

    // lowest matching hot slot wins
    always_comb begin
        hot_hit = 1'b0;
        hot_idx = '0;
        for (int k = HOT_ENTRIES - 1; k >= 0; k--) begin
            if (r_hot_valid[k] && (r_hot_handle[k] == i_head.handle)) begin
                hot_hit = 1'b1;
                hot_idx = HW'(k);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        rd_en       = 1'b0;
        finish      = 1'b0;
        hot_wr      = 1'b0;
        hot_wr_addr = i_head.mapper_addr;
        tbl_wr      = 1'b0;
        res_found   = 1'b0;
        res_addr    = '0;
        res_src     = SRC_FAIL;
        out_free    = !r_out_valid || i_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.bypass) begin
                        finish    = 1'b1;
                        res_found = i_head.mapper_ok;
                        res_addr  = i_head.mapper_ok ? i_head.mapper_addr : '0;
                        res_src   = SRC_BYPASS;
                    end else if (hot_hit) begin
                        finish    = 1'b1;
                        res_found = 1'b1;
                        res_addr  = r_hot_address[hot_idx];
                        res_src   = SRC_HOT;
                    end else begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend && (r_rd_data.handle == i_head.handle)) begin
                    finish      = 1'b1;
                    hot_wr      = 1'b1;
                    hot_wr_addr = r_rd_data.addr;
                    res_found   = 1'b1;
                    res_addr    = r_rd_data.addr;
                    res_src     = SRC_TABLE;
                end else if (!r_pend && (r_idx == r_fill)) begin
                    finish = 1'b1;
                    if (i_head.mapper_ok) begin
                        hot_wr    = 1'b1;
                        tbl_wr    = (r_fill < FW'(TABLE_ENTRIES));
                        res_found = 1'b1;
                        res_addr  = i_head.mapper_addr;
                        res_src   = SRC_NEW;
                    end
                end else begin
                    rd_en  = (r_idx < r_fill);
                    n_pend = rd_en;
                    if (rd_en) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        go = finish && out_free;
        if (go) begin
            n_state = ST_IDLE;
        end
    end

    assign o_pop         = go;
    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_mapped_addr = r_out_addr;
    assign o_source      = r_out_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_fill      <= '0;
            r_victim    <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < HOT_ENTRIES; k++) begin
                r_hot_valid[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (go && tbl_wr) begin
                r_fill <= r_fill + 1'b1;
            end
            if (go && hot_wr) begin
                r_hot_valid[r_victim] <= 1'b1;
                r_victim <= (r_victim == HW'(HOT_ENTRIES - 1)) ? '0 : r_victim + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_found <= res_found;
            r_out_addr  <= res_addr;
            r_out_src   <= res_src;
        end
        if (go && hot_wr) begin
            r_hot_handle[r_victim]  <= i_head.handle;
            r_hot_address[r_victim] <= hot_wr_addr;
        end
    end

    // main table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (go && tbl_wr) begin
            r_mem[r_fill[AW-1:0]] <= '{handle: i_head.handle, addr: i_head.mapper_addr};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

endmodule

>>> hw/rtl/two_level_handle_map_cache.sv
// Path: a bypass or hot-buffer hit is resolved at the queue head and registered at
//   the output; a main-table lookup reads the stored entries one at a time, in order.
// Throughput: bypass and hot hits 1 request per cycle while the result channel is ready;
//   a table lookup holds the back end until its scan through the single read port ends.
// Reset: synchronous, active low; clears the queue, hot valid bits, fill count,
//   victim pointer and output valid, and sets cache_enable to 1.
module two_level_handle_map_cache
    import thmc_pkg::*;
#(
    parameter int HOT_ENTRIES   = 16,
    parameter int TABLE_ENTRIES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_mapper_ok,
    input  logic [ADDR_W-1:0]   i_mapper_addr,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_found,
    output logic [ADDR_W-1:0]   o_mapped_addr,
    output logic [SRC_W-1:0]    o_source,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic r_cache_enable;
    logic head_valid;
    t_req head;
    logic pop;

    // Single register at byte address 0: every completed write lands on it.
    // paddr carries only the byte offset within that word.
    assign pready = 1'b1;
    assign prdata = {31'd0, r_cache_enable} | {30'd0, paddr & 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            r_cache_enable <= pwdata[0];
        end
    end

    // Front: accept and classify (bypass or lookup), hold up to two requests.
    thmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cache_enable (r_cache_enable),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_handle       (i_handle),
        .i_mapper_ok    (i_mapper_ok),
        .i_mapper_addr  (i_mapper_addr),
        .o_head_valid   (head_valid),
        .o_head         (head),
        .i_pop          (pop)
    );

    // Back: hot-buffer check, ordered table scan, update, and output register.
    thmc_back #(
        .HOT_ENTRIES   (HOT_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_mapped_addr (o_mapped_addr),
        .o_source      (o_source)
    );

endmodule
